// ===== rtl/bps_pkg.sv =====
// Shared codes for the beep pattern sequencer: item actions, pattern codes,
// configuration register indexes, register reset values and timing limits.
// No dependencies.
package bps_pkg;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_START = 2'd1,
    ACT_STOP  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef logic [3:0] pattern_t;

  localparam pattern_t PAT_ERROR      = 4'd0;
  localparam pattern_t PAT_CONFIRM_LO = 4'd1;
  localparam pattern_t PAT_CONFIRM_HI = 4'd6;
  localparam pattern_t PAT_ESCALATION = 4'd7;
  localparam pattern_t PAT_PERIMETER  = 4'd8;

  typedef enum logic [2:0] {
    REG_SHORT_BEEP    = 3'd0,
    REG_GAP           = 3'd1,
    REG_LONG_BEEP     = 3'd2,
    REG_CONFIRM_PAUSE = 3'd3,
    REG_ERROR_BEEP    = 3'd4,
    REG_PHASE1        = 3'd5,
    REG_PHASE2        = 3'd6,
    REG_PHASE3        = 3'd7
  } cfg_reg_t;

  localparam logic [15:0] RST_SHORT_BEEP    = 16'd80;
  localparam logic [15:0] RST_GAP           = 16'd80;
  localparam logic [15:0] RST_LONG_BEEP     = 16'd400;
  localparam logic [15:0] RST_CONFIRM_PAUSE = 16'd300;
  localparam logic [15:0] RST_ERROR_BEEP    = 16'd1000;
  localparam logic [15:0] RST_PHASE         = 16'd10000;

  localparam logic [17:0] ELAPSED_MAX  = 18'h3FFFF;
  localparam logic [9:0]  MS_LAST      = 10'd999;
  localparam logic [15:0] MS_PER_SEC   = 16'd1000;
  localparam logic [15:0] HALF_SEC_MS  = 16'd500;
  localparam int unsigned CONFIRM_TAIL = 6;

endpackage

// ===== rtl/beep_pattern_sequencer_core.sv =====
// Beep pattern sequencer top level: buzzer state, configuration registers
// and the output word register. Depends on bps_pkg.
//
//   channel   | direction | fields (lowest bit first)
//   s_axis    | in        | tuser: action[1:0]; tdata: pattern_id[3:0], zero fill
//   m_axis    | out       | tdata: buzzer_on, busy_res, active_pattern_out[3:0], zero fill
//   cfg       | in        | cfg_we, cfg_index[2:0], cfg_data[15:0], write only
//
// Every input word is handled in the cycle it is accepted: the buzzer state
// and the result are computed from the current state in one pass and both
// land in registers at that edge, so one word per cycle is sustained. The
// single output register is the limit; a new word is taken whenever that
// register is empty or is being drained in the same cycle. Reset (rst,
// synchronous) stops any pattern, empties the output and restores the
// register defaults. A stall on m_axis holds the result and pushes back.
module beep_pattern_sequencer_core
  import bps_pkg::*;
#(
  parameter int unsigned FAST_PERIOD_MS  = 166,
  parameter int unsigned PERIMETER_BEEPS = 5
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [3:0] pattern_id, [7:4] unused
  input  logic [1:0]  s_axis_tuser,   // [1:0] action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [0] buzzer_on, [1] busy_res,
                                      // [5:2] active_pattern_out, [7:6] zero
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam logic [15:0] FastPeriod = 16'(FAST_PERIOD_MS);
  localparam logic [3:0]  PerimCount = 4'(PERIMETER_BEEPS);

  // Configuration registers.
  logic [15:0] short_beep_ms, gap_ms, long_beep_ms, mid_pause_ms;
  logic [15:0] err_beep_ms, phase1_ms, phase2_ms, phase3_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      short_beep_ms <= RST_SHORT_BEEP;
      gap_ms        <= RST_GAP;
      long_beep_ms  <= RST_LONG_BEEP;
      mid_pause_ms  <= RST_CONFIRM_PAUSE;
      err_beep_ms   <= RST_ERROR_BEEP;
      phase1_ms     <= RST_PHASE;
      phase2_ms     <= RST_PHASE;
      phase3_ms     <= RST_PHASE;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_SHORT_BEEP:    short_beep_ms <= cfg_data;
        REG_GAP:           gap_ms        <= cfg_data;
        REG_LONG_BEEP:     long_beep_ms  <= cfg_data;
        REG_CONFIRM_PAUSE: mid_pause_ms  <= cfg_data;
        REG_ERROR_BEEP:    err_beep_ms   <= cfg_data;
        REG_PHASE1:        phase1_ms     <= cfg_data;
        REG_PHASE2:        phase2_ms     <= cfg_data;
        REG_PHASE3:        phase3_ms     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer state.
  pattern_t    current_pattern, current_pattern_next;
  logic        playing, playing_next;
  logic        pin_level, pin_level_next;
  logic [3:0]  step_index, step_index_next;
  logic [15:0] toggle_countdown, toggle_countdown_next;
  logic [17:0] elapsed_ms, elapsed_ms_next;
  logic [9:0]  ms_in_second, ms_in_second_next;
  logic [3:0]  beeps_left, beeps_left_next;

  logic      accept;
  action_t   action;
  pattern_t  pattern_id;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign action        = action_t'(s_axis_tuser);
  assign pattern_id    = s_axis_tdata[3:0];

  // Values a tick produces before the pattern logic looks at them.
  logic [15:0] cd_dec;
  logic [17:0] elapsed_inc;
  logic [9:0]  ms_inc;
  logic        due;

  assign cd_dec      = (toggle_countdown != '0) ? toggle_countdown - 16'd1 : '0;
  assign elapsed_inc = (elapsed_ms != ELAPSED_MAX) ? elapsed_ms + 18'd1 : elapsed_ms;
  assign ms_inc      = (ms_in_second >= MS_LAST) ? '0 : ms_in_second + 10'd1;
  assign due         = (cd_dec == '0);

  // Escalation phase boundaries and silent times.
  logic [16:0] phase12_end;
  logic [17:0] phase123_end;
  logic [15:0] slow_gap, half_gap, fast_gap;

  assign phase12_end  = {1'b0, phase1_ms} + {1'b0, phase2_ms};
  assign phase123_end = {1'b0, phase12_end} + {2'b00, phase3_ms};
  assign slow_gap     = MS_PER_SEC - {6'd0, ms_inc};
  assign half_gap     = (HALF_SEC_MS > short_beep_ms) ? HALF_SEC_MS - short_beep_ms : '0;
  assign fast_gap     = (FastPeriod > short_beep_ms) ? FastPeriod - short_beep_ms : '0;

  // Confirm pattern layout: the opening short beeps take the pattern code
  // rounded up to even steps, then the pause, then the closing part.
  logic [4:0] conf_before;
  logic [4:0] conf_step;
  logic [4:0] conf_tail;

  assign conf_before = {1'b0, current_pattern} + {4'd0, current_pattern[0]};
  assign conf_step   = {1'b0, step_index};
  assign conf_tail   = conf_step - conf_before - 5'd1;

  logic start_ok;
  assign start_ok = (pattern_id <= PAT_PERIMETER) &&
                    !((pattern_id == PAT_PERIMETER) && playing &&
                      ((current_pattern == PAT_ESCALATION) ||
                       (current_pattern == PAT_PERIMETER)));

  always_comb begin
    current_pattern_next  = current_pattern;
    playing_next          = playing;
    pin_level_next        = pin_level;
    step_index_next       = step_index;
    toggle_countdown_next = toggle_countdown;
    elapsed_ms_next       = elapsed_ms;
    ms_in_second_next     = ms_in_second;
    beeps_left_next       = beeps_left;

    if (accept) begin
      case (action)
        ACT_TICK: begin
          if (playing) begin
            toggle_countdown_next = cd_dec;
            elapsed_ms_next       = elapsed_inc;
            ms_in_second_next     = ms_inc;
            if (current_pattern == PAT_ESCALATION) begin
              if (elapsed_inc >= phase123_end) begin
                current_pattern_next = PAT_ERROR;
                playing_next         = 1'b0;
                step_index_next      = '0;
                pin_level_next       = 1'b0;
              end else if (due) begin
                if (!pin_level) begin
                  pin_level_next        = 1'b1;
                  toggle_countdown_next = short_beep_ms;
                end else begin
                  pin_level_next = 1'b0;
                  if (elapsed_inc < {2'b00, phase1_ms}) begin
                    toggle_countdown_next = slow_gap;
                  end else if (elapsed_inc < {1'b0, phase12_end}) begin
                    toggle_countdown_next = half_gap;
                  end else begin
                    toggle_countdown_next = fast_gap;
                  end
                end
              end
            end else if (due) begin
              // Halt is the fallback; the arms below override it.
              current_pattern_next = PAT_ERROR;
              playing_next         = 1'b0;
              step_index_next      = '0;
              pin_level_next       = 1'b0;
              if (current_pattern >= PAT_CONFIRM_LO &&
                  current_pattern <= PAT_CONFIRM_HI) begin
                if (conf_step < conf_before) begin
                  current_pattern_next  = current_pattern;
                  playing_next          = 1'b1;
                  pin_level_next        = !step_index[0];
                  toggle_countdown_next = step_index[0] ? gap_ms : short_beep_ms;
                  step_index_next       = step_index + 4'd1;
                end else if (conf_step == conf_before) begin
                  current_pattern_next  = current_pattern;
                  playing_next          = 1'b1;
                  pin_level_next        = 1'b0;
                  toggle_countdown_next = mid_pause_ms;
                  step_index_next       = step_index + 4'd1;
                end else if (current_pattern[0]) begin
                  if (conf_tail == '0) begin
                    current_pattern_next  = current_pattern;
                    playing_next          = 1'b1;
                    pin_level_next        = 1'b1;
                    toggle_countdown_next = long_beep_ms;
                    step_index_next       = step_index + 4'd1;
                  end
                end else if (conf_tail < 5'(CONFIRM_TAIL)) begin
                  current_pattern_next  = current_pattern;
                  playing_next          = 1'b1;
                  pin_level_next        = !conf_tail[0];
                  toggle_countdown_next = conf_tail[0] ? gap_ms : short_beep_ms;
                  step_index_next       = step_index + 4'd1;
                end
              end else if (current_pattern == PAT_PERIMETER) begin
                current_pattern_next = current_pattern;
                playing_next         = 1'b1;
                step_index_next      = step_index;
                if (pin_level) begin
                  pin_level_next = 1'b0;
                  if (beeps_left <= 4'd1) begin
                    // Last beep of the alert has ended.
                    beeps_left_next      = '0;
                    current_pattern_next = PAT_ERROR;
                    playing_next         = 1'b0;
                    step_index_next      = '0;
                  end else begin
                    beeps_left_next       = beeps_left - 4'd1;
                    toggle_countdown_next = gap_ms;
                  end
                end else begin
                  pin_level_next        = 1'b1;
                  toggle_countdown_next = short_beep_ms;
                end
              end
            end
          end
        end
        ACT_START: begin
          if (start_ok) begin
            current_pattern_next  = pattern_id;
            playing_next          = 1'b1;
            step_index_next       = '0;
            beeps_left_next       = '0;
            elapsed_ms_next       = '0;
            ms_in_second_next     = '0;
            toggle_countdown_next = '0;
            pin_level_next        = 1'b0;
            if (pattern_id == PAT_ERROR) begin
              pin_level_next        = 1'b1;
              toggle_countdown_next = err_beep_ms;
            end else if (pattern_id == PAT_ESCALATION) begin
              pin_level_next        = 1'b1;
              toggle_countdown_next = short_beep_ms;
            end else if (pattern_id == PAT_PERIMETER) begin
              beeps_left_next       = PerimCount;
              pin_level_next        = 1'b1;
              toggle_countdown_next = short_beep_ms;
            end
          end
        end
        ACT_STOP: begin
          current_pattern_next = PAT_ERROR;
          playing_next         = 1'b0;
          step_index_next      = '0;
          pin_level_next       = 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_pattern  <= '0;
      playing          <= 1'b0;
      pin_level        <= 1'b0;
      step_index       <= '0;
      toggle_countdown <= '0;
      elapsed_ms       <= '0;
      ms_in_second     <= '0;
      beeps_left       <= '0;
    end else begin
      current_pattern  <= current_pattern_next;
      playing          <= playing_next;
      pin_level        <= pin_level_next;
      step_index       <= step_index_next;
      toggle_countdown <= toggle_countdown_next;
      elapsed_ms       <= elapsed_ms_next;
      ms_in_second     <= ms_in_second_next;
      beeps_left       <= beeps_left_next;
    end
  end

  // Output word register: loaded with the state after each accepted word.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (accept) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_axis_tdata <= {2'b00,
                       playing_next ? current_pattern_next : PAT_ERROR,
                       playing_next,
                       pin_level_next};
    end
  end

endmodule

// ===== test/beep_pattern_sequencer_core_tb.sv =====
// Self-checking testbench for beep_pattern_sequencer_core: directed and random stream traffic
// with a cycle-free predictor of the buzzer state held in a small scoreboard class.
// Depends on bps_pkg and the core RTL only.
`timescale 1ns / 1ps

module beep_pattern_sequencer_core_tb;
  import bps_pkg::*;

  localparam int unsigned FAST_PERIOD_MS  = 166;
  localparam int unsigned PERIMETER_BEEPS = 5;
  localparam int RESET_CYCLES  = 12;
  localparam int SETTLE_CYCLES = 8;    // output register depth plus margin
  localparam int LONG_HOLD     = 80;   // receiver hold-off that backs up the input
  localparam int STALL_LIMIT   = 400;  // cycles without any accepted word
  localparam int MAX_REPORTS   = 100;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;    // [3:0] pattern_id, [7:4] zero
  logic [1:0]  s_axis_tuser = '0;    // [1:0] action
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;         // [0] buzzer_on, [1] busy_res,
                                     // [5:2] active_pattern_out, [7:6] zero
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  beep_pattern_sequencer_core #(
    .FAST_PERIOD_MS (FAST_PERIOD_MS),
    .PERIMETER_BEEPS(PERIMETER_BEEPS)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // One expected output word: pin level, busy flag and the reported pattern.
  typedef struct {
    bit       buzzer;
    bit       busy;
    pattern_t pat;
  } buzzer_word_t;

  // Scoreboard: keeps its own copy of the buzzer state and the registers,
  // advances it for every accepted input word and queues the expected output.
  class buzzer_scoreboard;
    logic [15:0]  regs [8];
    pattern_t     cur_pat;
    bit           playing;
    bit           pin;
    logic [3:0]   step;
    logic [15:0]  countdown;
    logic [17:0]  elapsed;
    logic [9:0]   ms_sec;
    logic [3:0]   beeps_left;
    buzzer_word_t expected_q [$];
    int           errors;

    function new();
      regs[REG_SHORT_BEEP]    = RST_SHORT_BEEP;
      regs[REG_GAP]           = RST_GAP;
      regs[REG_LONG_BEEP]     = RST_LONG_BEEP;
      regs[REG_CONFIRM_PAUSE] = RST_CONFIRM_PAUSE;
      regs[REG_ERROR_BEEP]    = RST_ERROR_BEEP;
      regs[REG_PHASE1]        = RST_PHASE;
      regs[REG_PHASE2]        = RST_PHASE;
      regs[REG_PHASE3]        = RST_PHASE;
      cur_pat    = PAT_ERROR;
      playing    = 1'b0;
      pin        = 1'b0;
      step       = '0;
      countdown  = '0;
      elapsed    = '0;
      ms_sec     = '0;
      beeps_left = '0;
      errors     = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void set_reg(cfg_reg_t r, logic [15:0] v);
      regs[r] = v;
    endfunction

    // A stop, or the natural end of a pattern. Timers are left as they are.
    function void silence();
      cur_pat = PAT_ERROR;
      playing = 1'b0;
      step    = '0;
      pin     = 1'b0;
    endfunction

    function logic [15:0] floor_sub(int unsigned a, int unsigned b);
      return (a > b) ? 16'(a - b) : 16'd0;
    endfunction

    function void short_step(bit on);
      pin       = on;
      countdown = on ? regs[REG_SHORT_BEEP] : regs[REG_GAP];
      step      = step + 1'b1;
    endfunction

    // Confirm patterns: lead-in short beeps, a pause, then either one long
    // beep (odd codes) or a tail of three short beeps (even codes).
    function void confirm_step();
      int unsigned lead;
      int unsigned s;
      int unsigned k;
      lead = ((int'(cur_pat) + 1) / 2) * 2;
      s    = step;
      if (s < lead) begin
        short_step(s[0] == 1'b0);
        return;
      end
      if (s == lead) begin
        pin       = 1'b0;
        countdown = regs[REG_CONFIRM_PAUSE];
        step      = step + 1'b1;
        return;
      end
      if (cur_pat[0]) begin
        if (s == lead + 1) begin
          pin       = 1'b1;
          countdown = regs[REG_LONG_BEEP];
          step      = step + 1'b1;
        end else begin
          silence();
        end
        return;
      end
      k = s - (lead + 1);
      if (k < CONFIRM_TAIL) short_step(k[0] == 1'b0);
      else silence();
    endfunction

    // Escalation: the end test runs on every tick; the silent time depends
    // on the phase and saturates at zero in the two faster phases.
    function void escalation_step(bit due);
      int unsigned p1;
      int unsigned p2;
      int unsigned p3;
      p1 = regs[REG_PHASE1];
      p2 = regs[REG_PHASE2];
      p3 = regs[REG_PHASE3];
      if (elapsed >= p1 + p2 + p3) begin
        silence();
        return;
      end
      if (!due) return;
      if (!pin) begin
        pin       = 1'b1;
        countdown = regs[REG_SHORT_BEEP];
        return;
      end
      pin = 1'b0;
      if (elapsed < p1) countdown = MS_PER_SEC - ms_sec;
      else if (elapsed < p1 + p2) countdown = floor_sub(HALF_SEC_MS, regs[REG_SHORT_BEEP]);
      else countdown = floor_sub(FAST_PERIOD_MS, regs[REG_SHORT_BEEP]);
    endfunction

    function void perimeter_step();
      if (pin) begin
        pin = 1'b0;
        if (beeps_left <= 1) begin
          beeps_left = '0;
          silence();
          return;
        end
        beeps_left = beeps_left - 1'b1;
        countdown  = regs[REG_GAP];
      end else begin
        pin       = 1'b1;
        countdown = regs[REG_SHORT_BEEP];
      end
    endfunction

    function void tick();
      bit due;
      if (!playing) return;
      if (countdown != 0) countdown = countdown - 1'b1;
      if (elapsed < ELAPSED_MAX) elapsed = elapsed + 1'b1;
      ms_sec = (ms_sec >= MS_LAST) ? '0 : ms_sec + 1'b1;
      due    = (countdown == 0);
      if (cur_pat == PAT_ESCALATION) begin
        escalation_step(due);
        return;
      end
      if (!due) return;
      if (cur_pat == PAT_ERROR) silence();
      else if (cur_pat <= PAT_CONFIRM_HI) confirm_step();
      else if (cur_pat == PAT_PERIMETER) perimeter_step();
      else silence();
    endfunction

    // Unknown codes are dropped, and a perimeter alert cannot cut into an
    // escalation or another perimeter alert.
    function void launch(pattern_t id);
      if (id > PAT_PERIMETER) return;
      if (id == PAT_PERIMETER && playing &&
          (cur_pat == PAT_ESCALATION || cur_pat == PAT_PERIMETER)) return;
      cur_pat    = id;
      playing    = 1'b1;
      step       = '0;
      beeps_left = '0;
      elapsed    = '0;
      ms_sec     = '0;
      countdown  = '0;
      pin        = 1'b0;
      if (id == PAT_ERROR) begin
        pin       = 1'b1;
        countdown = regs[REG_ERROR_BEEP];
      end else if (id == PAT_ESCALATION) begin
        pin       = 1'b1;
        countdown = regs[REG_SHORT_BEEP];
      end else if (id == PAT_PERIMETER) begin
        beeps_left = 4'(PERIMETER_BEEPS);
        pin        = 1'b1;
        countdown  = regs[REG_SHORT_BEEP];
      end
    endfunction

    function void note_input(action_t act, pattern_t id);
      buzzer_word_t w;
      case (act)
        ACT_TICK:  tick();
        ACT_START: launch(id);
        ACT_STOP:  silence();
        default: ;
      endcase
      w.buzzer = pin;
      w.busy   = playing;
      w.pat    = playing ? cur_pat : '0;
      expected_q.push_back(w);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(logic [7:0] word);
      buzzer_word_t w;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: output word %h with nothing expected", $time, word);
        return;
      end
      w = expected_q.pop_front();
      compare_field("buzzer_on", w.buzzer, word[0]);
      compare_field("busy_res", w.busy, word[1]);
      compare_field("active_pattern_out", w.pat, word[5:2]);
      compare_field("zero fill", 0, word[7:6]);
    endfunction
  endclass

  buzzer_scoreboard sb;
  int idle_pct     = 0;     // chance per word of an idle burst, in percent
  bit quiet        = 1'b0;  // set for the closing stretch: no idling at all
  bit hold_request = 1'b0;  // asks the receiver for one long hold-off

  always #5 clk = ~clk;

  // Monitor. Outputs are sampled at the rising edge, before the design's
  // registers update, and the result check comes before the new input is
  // noted, since a result never belongs to the word accepted at the same edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready)
        sb.note_input(action_t'(s_axis_tuser), s_axis_tdata[3:0]);
    end
  end

  // Watchdog: a run that stops moving words for too long has hung.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAIL beep_pattern_sequencer_core");
        $finish;
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request so the
  // output register fills and the core has to push back on its input.
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left   = LONG_HOLD;
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else if (!quiet && idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
        m_axis_tready <= 1'b0;
        stall_left = $urandom_range(0, 11);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Offers one word at the falling edge and returns at the falling edge after
  // it was taken. Valid stays high into the next word unless a gap is drawn.
  task automatic send_word(action_t act, pattern_t id);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {4'b0000, id};
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
    if (!quiet && idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  endtask

  function automatic pattern_t any_id();
    return pattern_t'($urandom_range(0, 15));
  endfunction

  // Stray commands: stops, the unused action, unknown codes, a perimeter
  // alert that may collide with a running one, or a restart.
  task automatic send_noise();
    case ($urandom_range(0, 4))
      0: send_word(ACT_STOP, any_id());
      1: send_word(ACT_NONE, any_id());
      2: send_word(ACT_START, pattern_t'($urandom_range(PAT_PERIMETER + 1, 15)));
      3: send_word(ACT_START, PAT_PERIMETER);
      default: send_word(ACT_START, pattern_t'($urandom_range(PAT_ERROR, PAT_PERIMETER)));
    endcase
  endtask

  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  task automatic drain();
    wait_for_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Writes all eight registers on consecutive edges; only called while idle.
  task automatic configure(input logic [15:0] short_ms, gap_ms, long_ms, pause_ms,
                           error_ms, p1_ms, p2_ms, p3_ms);
    logic [15:0] vals [8];
    int i;
    vals = '{short_ms, gap_ms, long_ms, pause_ms, error_ms, p1_ms, p2_ms, p3_ms};
    for (i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= cfg_reg_t'(i);
      cfg_data  <= vals[i];
      sb.set_reg(cfg_reg_t'(i), vals[i]);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // Random traffic made mostly of well-formed runs: a start followed by a
  // random stretch of ticks, salted with noise; stress adds a hold-off and a pause.
  task automatic run_phase(int budget, int span_lo, int span_hi, int esc_pct,
                           int noise_pct, bit stress);
    int n;
    int len;
    bit held;
    bit paused;
    n      = 0;
    held   = 1'b0;
    paused = 1'b0;
    while (n < budget) begin
      if (stress && !held && n >= budget / 2) begin
        held         = 1'b1;
        hold_request = 1'b1;
      end
      if (stress && !paused && n >= (3 * budget) / 4) begin
        paused = 1'b1;
        wait_for_results();
      end
      if ($urandom_range(0, 99) < esc_pct) send_word(ACT_START, PAT_ESCALATION);
      else send_word(ACT_START, pattern_t'($urandom_range(PAT_ERROR, PAT_PERIMETER)));
      n++;
      len = $urandom_range(span_lo, span_hi);
      repeat (len) begin
        if ($urandom_range(0, 99) < noise_pct) send_noise();
        else send_word(ACT_TICK, any_id());
        n++;
      end
      if ($urandom_range(0, 9) == 0) begin
        send_word(ACT_STOP, any_id());
        n++;
      end
    end
  endtask

  initial begin
    pattern_t id;
    sb = new();
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed opening at the reset register values: every action, every
    // pattern code, unknown codes, and the perimeter alert refused while an
    // escalation or another alert is playing.
    idle_pct = 20;
    send_word(ACT_START, PAT_ERROR);
    send_word(ACT_TICK, '0);
    send_word(ACT_STOP, '0);
    send_word(ACT_TICK, '1);
    for (id = PAT_CONFIRM_LO; id <= PAT_CONFIRM_HI; id++) begin
      send_word(ACT_START, id);
      send_word(ACT_TICK, id);
    end
    send_word(ACT_START, PAT_ESCALATION);
    send_word(ACT_START, PAT_PERIMETER);
    send_word(ACT_TICK, '0);
    send_word(ACT_STOP, '0);
    send_word(ACT_START, PAT_PERIMETER);
    send_word(ACT_START, PAT_PERIMETER);
    send_word(ACT_START, PAT_ESCALATION);
    send_word(ACT_NONE, '1);
    send_word(ACT_START, pattern_t'(PAT_PERIMETER + 1));
    send_word(ACT_START, '1);
    send_word(ACT_STOP, '1);
    drain();

    // Shortest legal timings; an escalation with all phases at zero ends on
    // its first tick.
    idle_pct = 25;
    configure(1, 1, 1, 1, 1, 0, 0, 0);
    run_phase(50, 1, 12, 10, 8, 1'b0);
    drain();

    // Small timings; this phase also carries the long receiver hold-off and
    // a sender pause until every result is back.
    idle_pct = 15;
    configure(2, 3, 4, 2, 5, 20, 10, 10);
    run_phase(100, 10, 30, 15, 6, 1'b1);
    drain();

    // Another small setting, run with no idling on either side.
    idle_pct = 0;
    configure(3, 1, 2, 5, 2, 1, 1, 1);
    run_phase(40, 5, 20, 10, 6, 1'b0);
    drain();

    // One full escalation with a short beep of exactly half a second: no
    // silence is left in phase two or in phase three, and the millisecond
    // counter wraps before the run ends.
    idle_pct = 5;
    configure(500, 2, 5, 3, 4, 0, 1000, 5);
    run_phase(1, 1008, 1012, 100, 0, 1'b0);
    drain();

    // Largest values: nothing finishes, starts and stops still have to land.
    idle_pct = 30;
    configure('1, '1, '1, '1, '1, '1, '1, '1);
    run_phase(30, 5, 20, 20, 10, 1'b0);
    drain();

    // Random small settings.
    idle_pct = 20;
    configure(16'($urandom_range(1, 8)), 16'($urandom_range(1, 8)),
              16'($urandom_range(1, 8)), 16'($urandom_range(1, 8)),
              16'($urandom_range(1, 8)), 16'($urandom_range(0, 40)),
              16'($urandom_range(0, 40)), 16'($urandom_range(0, 40)));
    run_phase(60, 5, 30, 15, 6, 1'b0);
    drain();

    // Closing stretch at the reset values with both sides always ready.
    quiet = 1'b1;
    configure(RST_SHORT_BEEP, RST_GAP, RST_LONG_BEEP, RST_CONFIRM_PAUSE,
              RST_ERROR_BEEP, RST_PHASE, RST_PHASE, RST_PHASE);
    run_phase(40, 15, 40, 10, 5, 1'b0);
    drain();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS beep_pattern_sequencer_core");
    end else begin
      $display("FAIL beep_pattern_sequencer_core");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/bps_pkg.sv
rtl/beep_pattern_sequencer_core.sv
test/beep_pattern_sequencer_core_tb.sv
